@@ hw/rtl/assert_macros.svh @@
// Concurrent assertion helpers, clocked on the rising edge, quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/pttt_pkg.sv @@
`timescale 1ns / 1ps

package pttt_pkg;

    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_POLL     = 3'd1;
    localparam logic [2:0] REQ_FINISH   = 3'd2;
    localparam logic [2:0] REQ_ENABLE   = 3'd3;
    localparam logic [2:0] REQ_READ_MAX = 3'd4;
    localparam logic [2:0] REQ_TIMEOUT  = 3'd5;

    typedef struct packed {
        logic [63:0] last_run_ms;
        logic [63:0] run_start_ms;
        logic [31:0] longest_run_ms;
        logic        enabled;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        last_run_ms:    64'd0,
        run_start_ms:   64'd0,
        longest_run_ms: 32'd0,
        enabled:        1'b1
    };

endpackage

@@ hw/rtl/periodic_task_timer_table.sv @@
`timescale 1ns / 1ps

// Periodic task timer table: a 64-bit millisecond count and NUM_TIMERS timers.
// Command channel: an item is taken at a rising edge with start high and busy
// low; req_type, timer_index, interval_ms, start_ms and enable_value are
// sampled there. Busy is registered from acceptance and is high only in the cycle after it.
// Result channel: done is high for exactly one cycle carrying fire,
// max_exec_ms, timed_out and bad_index; the receiver cannot stall, so each
// result is taken at the edge that ends that cycle.
// Result path: the table is read at acceptance, then the compare and
// write-back happen while busy is high, and the result is registered with done.
// A new item is not taken while busy is high, since the single-port table
// read is followed by its write-back.
// Timer table: one synchronous memory, one entry per timer, read-modify-write.
// Items are handled one at a time, so a write always lands before the next
// read. Per-entry valid flags make an unwritten entry read as its reset value.
// Reset: count cleared, all timers enabled with zero times, no clearing pass;
// the block can accept an item as soon as reset is released.
module periodic_task_timer_table #(
    parameter int NUM_TIMERS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [7:0]  timer_index,
    input  logic [31:0] interval_ms,
    input  logic [31:0] start_ms,
    input  logic        enable_value,
    output logic        done,
    output logic        fire,
    output logic [31:0] max_exec_ms,
    output logic        timed_out,
    output logic        bad_index
);

    import pttt_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [8:0] NT = 9'(NUM_TIMERS);

    entry_t                  mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   valid_reg;
    logic [NUM_TIMERS-1:0]   valid_next;

    logic                    busy_reg;
    logic                    done_reg;
    logic [63:0]             now_reg;
    logic [63:0]             now_next;

    logic [2:0]              req_reg;
    logic [IW-1:0]           idx_reg;
    logic                    in_range_reg;
    logic [31:0]             interval_reg;
    logic [31:0]             start_ms_reg;
    logic                    enable_reg;
    entry_t                  rd_data_reg;
    logic                    rd_valid_reg;

    logic                    fire_reg;
    logic [31:0]             max_reg;
    logic                    timed_out_reg;
    logic                    bad_reg;
    logic                    fire_next;
    logic [31:0]             max_next;
    logic                    timed_out_next;
    logic                    bad_next;

    logic                    accept;
    logic                    in_range;
    logic [IW-1:0]           idx;
    entry_t                  cur;
    entry_t                  wr_data;
    logic                    wr_en;
    logic [63:0]             since_run;
    logic [63:0]             since_start;
    logic [31:0]             elapsed;

    assign accept   = start && !busy_reg;
    assign idx      = timer_index[IW-1:0];
    assign in_range = {1'b0, timer_index} < NT;

    always_comb
    begin
        cur            = rd_valid_reg ? rd_data_reg : ENTRY_RESET;
        wr_data        = cur;
        wr_en          = 1'b0;
        now_next       = now_reg;
        valid_next     = valid_reg;
        fire_next      = 1'b0;
        max_next       = 32'd0;
        timed_out_next = 1'b0;
        bad_next       = 1'b0;
        since_run      = now_reg - cur.last_run_ms;
        since_start    = now_reg - {32'd0, start_ms_reg};
        elapsed        = now_reg[31:0] - cur.run_start_ms[31:0];
        case (req_reg)
            REQ_TICK:
            begin
                now_next = now_reg + 64'd1;
            end
            REQ_POLL:
            begin
                if (!in_range_reg)
                begin
                    bad_next = 1'b1;
                end
                else if (cur.enabled && (since_run >= {32'd0, interval_reg}))
                begin
                    fire_next            = 1'b1;
                    wr_data.run_start_ms = now_reg;
                    wr_en                = 1'b1;
                end
            end
            REQ_FINISH:
            begin
                if (!in_range_reg)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    if (elapsed > cur.longest_run_ms)
                    begin
                        wr_data.longest_run_ms = elapsed;
                    end
                    wr_data.last_run_ms = now_reg;
                    wr_en               = 1'b1;
                end
            end
            REQ_ENABLE:
            begin
                if (!in_range_reg)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    wr_data.enabled = enable_reg;
                    wr_en           = 1'b1;
                end
            end
            REQ_READ_MAX:
            begin
                if (!in_range_reg)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    max_next = cur.longest_run_ms;
                end
            end
            REQ_TIMEOUT:
            begin
                timed_out_next = since_start > {32'd0, interval_reg};
            end
            default:
            begin
                now_next = now_reg;
            end
        endcase
        if (!busy_reg)
        begin
            wr_en    = 1'b0;
            now_next = now_reg;
        end
        if (wr_en)
        begin
            valid_next[idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            now_reg   <= 64'd0;
            valid_reg <= '0;
        end
        else
        begin
            busy_reg  <= accept;
            done_reg  <= busy_reg;
            now_reg   <= now_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= req_type;
            idx_reg      <= idx;
            in_range_reg <= in_range;
            interval_reg <= interval_ms;
            start_ms_reg <= start_ms;
            enable_reg   <= enable_value;
            rd_valid_reg <= in_range && valid_reg[idx];
        end
        if (busy_reg)
        begin
            fire_reg      <= fire_next;
            max_reg       <= max_next;
            timed_out_reg <= timed_out_next;
            bad_reg       <= bad_next;
        end
    end

    // table memory: registered read at acceptance, write-back in the next cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[idx];
        end
        if (wr_en)
        begin
            mem[idx_reg] <= wr_data;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign fire        = fire_reg;
    assign max_exec_ms = max_reg;
    assign timed_out   = timed_out_reg;
    assign bad_index   = bad_reg;

endmodule

@@ hw/rtl/pttt_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pttt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  req_type,
    input logic        done,
    input logic        fire,
    input logic        timed_out,
    input logic        bad_index
);

    import pttt_pkg::*;

    logic tick_accept;
    logic result_clean;

    assign tick_accept  = start && !busy && (req_type == REQ_TICK);
    assign result_clean = done && !fire && !timed_out && !bad_index;

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_busy_done, clk, rst_n, busy, !busy && done)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_IMPLY(a_flags_excl, clk, rst_n, done, $onehot0({fire, timed_out, bad_index}))
    `ASSERT_NEXT(a_tick_clean, clk, rst_n, tick_accept, ##1 result_clean)

endmodule

bind periodic_task_timer_table pttt_checker u_pttt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .done      (done),
    .fire      (fire),
    .timed_out (timed_out),
    .bad_index (bad_index)
);
